// File: rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int OPERAND_BITS_DEF = 16;
	localparam int RES_NUM_W = 32;
	localparam int RES_DEN_W = 31;

	typedef enum logic [3:0] {
		CMD_ADD = 4'd0,
		CMD_SUB = 4'd1,
		CMD_MUL = 4'd2,
		CMD_DIV = 4'd3,
		CMD_EQ  = 4'd4,
		CMD_NE  = 4'd5,
		CMD_GE  = 4'd6,
		CMD_LE  = 4'd7,
		CMD_GT  = 4'd8,
		CMD_LT  = 4'd9
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_FORM,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_DSTP,
		ST_FIN,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic form;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic div_save_n;
		logic finish;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic skip_gcd;
		logic gcd_done;
		logic div_done;
	} stat_t;

endpackage

// File: rtl/core/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath
// cross products, binary gcd and restoring divisions for the reduced result
// ----------------------------------------------------------------------------
module rau_datapath import rau_pkg::*; #(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  logic                        clk,
	input  ctrl_t                       ctrl,
	output stat_t                       stat,
	input  logic [3:0]                  command,
	input  logic signed [OPERAND_BITS-1:0] operand_a_num,
	input  logic [OPERAND_BITS-2:0]     operand_a_den,
	input  logic signed [OPERAND_BITS-1:0] operand_b_num,
	input  logic [OPERAND_BITS-2:0]     operand_b_den,
	output logic signed [RES_NUM_W-1:0] result_num,
	output logic [RES_DEN_W-1:0]        result_den,
	output logic                        compare_true,
	output logic                        divide_by_zero
);
	localparam int PW = 2 * OPERAND_BITS + 1;   // sum of two products
	localparam int MW = 2 * OPERAND_BITS;       // magnitudes
	localparam int CW = $clog2(MW + 1);
	localparam int SW = $clog2(MW + 2);

	logic [3:0] cmd_q;
	logic signed [OPERAND_BITS-1:0] an_q, bn_q;
	logic [OPERAND_BITS-2:0] ad_q, bd_q;
	logic signed [PW-1:0] left_q, right_q, n_q, d_q;
	logic [MW-1:0] u_q, v_q, nm_q, dm_q;
	logic [CW-1:0] sh_q;
	logic neg_q, dz_q, zero_q;
	// divider
	logic [MW-1:0] quo_q, rem_q, dvs_q;
	logic [SW-1:0] cnt_q;
	logic [MW-1:0] nq_q;

	logic signed [OPERAND_BITS:0] an_x, bn_x, ad_x, bd_x;
	assign an_x = {an_q[OPERAND_BITS-1], an_q};
	assign bn_x = {bn_q[OPERAND_BITS-1], bn_q};
	assign ad_x = {2'b00, ad_q};
	assign bd_x = {2'b00, bd_q};

	// cross products a_num * b_den and b_num * a_den
	logic signed [2*OPERAND_BITS+1:0] p1, p2;
	always_comb begin
		p1 = an_x * bd_x;
		p2 = bn_x * ad_x;
	end

	logic signed [PW-1:0] nf, df;
	logic arith;
	always_comb begin
		arith = 1'b1;
		nf = '0;
		df = d_q;
		case (cmd_q)
			CMD_ADD: nf = left_q + right_q;
			CMD_SUB: nf = left_q - right_q;
			CMD_MUL: nf = n_q;
			CMD_DIV: nf = left_q;
			default: arith = 1'b0;
		endcase
	end

	logic [MW-1:0] diff;
	assign diff = (u_q > v_q) ? u_q - v_q : v_q - u_q;

	logic [MW:0] trial;
	assign trial = {rem_q, quo_q[MW-1]} - {1'b0, dvs_q};

	logic cmp;
	always_comb begin
		case (cmd_q)
			CMD_EQ:  cmp = left_q == right_q;
			CMD_NE:  cmp = left_q != right_q;
			CMD_GE:  cmp = left_q >= right_q;
			CMD_LE:  cmp = left_q <= right_q;
			CMD_GT:  cmp = left_q > right_q;
			CMD_LT:  cmp = left_q < right_q;
			default: cmp = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= command;
			an_q <= operand_a_num;
			ad_q <= operand_a_den;
			bn_q <= operand_b_num;
			bd_q <= operand_b_den;
		end
		if (ctrl.mul1) begin
			left_q  <= PW'(p1);
			right_q <= PW'(p2);
		end
		if (ctrl.mul2) begin
			n_q <= PW'(an_x * bn_x);
			d_q <= PW'((cmd_q == CMD_DIV) ? ad_x * bn_x : ad_x * bd_x);
		end
		if (ctrl.form) begin
			neg_q <= (nf < 0) ^ (df < 0);
			nm_q <= MW'(nf < 0 ? -nf : nf);
			dm_q <= MW'(df < 0 ? -df : df);
			u_q  <= MW'(nf < 0 ? -nf : nf);
			v_q  <= MW'(df < 0 ? -df : df);
			sh_q <= '0;
			dz_q <= (cmd_q == CMD_DIV) && (bn_q == '0);
			zero_q <= !arith || nf == '0 || df == '0;
			compare_true <= cmp;
		end
		if (ctrl.gcd_step) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				sh_q <= sh_q + 1'b1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else begin
				u_q <= (u_q < v_q) ? u_q : v_q;
				v_q <= diff;
			end
		end
		if (ctrl.div_init) begin
			quo_q <= ctrl.div_save_n ? dm_q : nm_q;
			rem_q <= '0;
			dvs_q <= (u_q << sh_q);
			cnt_q <= '0;
		end
		if (ctrl.div_step) begin
			if (!trial[MW]) begin
				rem_q <= trial[MW-1:0];
				quo_q <= {quo_q[MW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[MW-2:0], quo_q[MW-1]};
				quo_q <= {quo_q[MW-2:0], 1'b0};
			end
			cnt_q <= cnt_q + 1'b1;
		end
		if (ctrl.div_save_n && ctrl.div_init)
			nq_q <= quo_q;
		if (ctrl.finish) begin
			divide_by_zero <= dz_q;
			if (zero_q) begin
				result_num <= '0;
				result_den <= RES_DEN_W'(1);
			end else begin
				result_num <= neg_q ? -RES_NUM_W'(nq_q) : RES_NUM_W'(nq_q);
				result_den <= RES_DEN_W'(quo_q);
			end
		end
	end

	assign stat.skip_gcd = zero_q;
	assign stat.gcd_done = (v_q == '0);
	assign stat.div_done = (cnt_q == SW'(MW - 1)) && ctrl.div_step;
endmodule

// File: rtl/core/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer for one transaction of the rational unit
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	output logic  done,
	output ctrl_t ctrl,
	input  stat_t stat
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ctrl = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				ctrl.load = start;
				if (start)
					state_d = ST_MUL1;
			end
			ST_MUL1: begin
				ctrl.mul1 = 1'b1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				ctrl.mul2 = 1'b1;
				state_d = ST_FORM;
			end
			ST_FORM: begin
				ctrl.form = 1'b1;
				state_d = ST_GCD;
			end
			ST_GCD: begin
				// zero results skip the reduction
				if (stat.skip_gcd) begin
					ctrl.finish = 1'b1;
					state_d = ST_DONE;
				end else if (stat.gcd_done) begin
					ctrl.div_init = 1'b1;
					state_d = ST_DIVN;
				end else begin
					ctrl.gcd_step = 1'b1;
				end
			end
			ST_DIVN: begin
				ctrl.div_step = 1'b1;
				if (stat.div_done)
					state_d = ST_DIVD;
			end
			ST_DIVD: begin
				// first pass left the numerator quotient; start denominator
				ctrl.div_init = 1'b1;
				ctrl.div_save_n = 1'b1;
				state_d = ST_DSTP;
			end
			ST_DSTP: begin
				ctrl.div_step = 1'b1;
				if (stat.div_done)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				ctrl.finish = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				done = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// File: rtl/core/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// add, subtract, multiply, divide and compare two fractions, reduced result
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The result is
// shown for one cycle with done high and cannot be held off. Comparisons,
// zero results and unused commands skip the reduction and go from the
// cross products straight to done. Other results pass through the cross
// products, the binary gcd steps and two bit-serial divisions of 32 steps
// each with a setup state between, then the result is registered before
// done. The gcd loop and the shared divider set the latency; a new
// transaction can be taken in the cycle after done.
module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	output logic                        done,
	input  logic [3:0]                  command,
	input  logic signed [OPERAND_BITS-1:0] operand_a_num,
	input  logic [OPERAND_BITS-2:0]     operand_a_den,
	input  logic signed [OPERAND_BITS-1:0] operand_b_num,
	input  logic [OPERAND_BITS-2:0]     operand_b_den,
	output logic signed [RES_NUM_W-1:0] result_num,
	output logic [RES_DEN_W-1:0]        result_den,
	output logic                        compare_true,
	output logic                        divide_by_zero
);
	ctrl_t ctrl;
	stat_t stat;

	// sequencer
	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.ctrl(ctrl), .stat(stat)
	);

	// arithmetic
	rau_datapath #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
		.clk(clk), .ctrl(ctrl), .stat(stat),
		.command(command), .operand_a_num(operand_a_num),
		.operand_a_den(operand_a_den), .operand_b_num(operand_b_num),
		.operand_b_den(operand_b_den), .result_num(result_num),
		.result_den(result_den), .compare_true(compare_true),
		.divide_by_zero(divide_by_zero)
	);

`ifndef NO_ASSERTIONS
	// a result only while a transaction is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done outside transaction");
	// result one cycle only
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	// a result flag never both
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(compare_true && divide_by_zero)) else $error("both flags");
`endif
endmodule

// File: dv/rau_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rau_checker
// predicts each fraction result from the accepted transaction and compares
// ----------------------------------------------------------------------------
module rau_checker import rau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        done,
	input  logic [3:0]  command,
	input  logic signed [15:0] operand_a_num,
	input  logic [14:0] operand_a_den,
	input  logic signed [15:0] operand_b_num,
	input  logic [14:0] operand_b_den,
	input  logic signed [31:0] result_num,
	input  logic [30:0] result_den,
	input  logic        compare_true,
	input  logic        divide_by_zero,
	output int          errors,
	output int          pending
);

	typedef struct {
		logic signed [31:0] num;
		logic [30:0]        den;
		logic               cmp;
		logic               dz;
	} fraction_t;

	fraction_t awaited_fractions[$];

	function automatic longint unsigned euclid_gcd(longint unsigned p, longint unsigned q);
		longint unsigned r;
		while (q != 0) begin
			r = p % q;
			p = q;
			q = r;
		end
		return p;
	endfunction

	function automatic fraction_t reduce_fraction(logic [3:0] op, longint an, longint ad,
			longint bn, longint bd);
		fraction_t f;
		longint n, d, lhs, rhs;
		longint unsigned g;
		bit arith;
		n = 0;
		d = 1;
		arith = 1;
		f.cmp = 0;
		f.dz = 0;
		lhs = an * bd;
		rhs = bn * ad;
		case (op)
			CMD_ADD: begin n = lhs + rhs; d = ad * bd; end
			CMD_SUB: begin n = lhs - rhs; d = ad * bd; end
			CMD_MUL: begin n = an * bn; d = ad * bd; end
			CMD_DIV: begin
				if (bn == 0) f.dz = 1;
				else begin
					n = lhs;
					d = ad * bn;
				end
			end
			CMD_EQ: begin arith = 0; f.cmp = (lhs == rhs); end
			CMD_NE: begin arith = 0; f.cmp = (lhs != rhs); end
			CMD_GE: begin arith = 0; f.cmp = (lhs >= rhs); end
			CMD_LE: begin arith = 0; f.cmp = (lhs <= rhs); end
			CMD_GT: begin arith = 0; f.cmp = (lhs > rhs); end
			CMD_LT: begin arith = 0; f.cmp = (lhs < rhs); end
			default: arith = 0;
		endcase
		if (arith && d < 0) begin
			d = -d;
			n = -n;
		end
		if (!arith || n == 0 || d == 0) begin
			n = 0;
			d = 1;
		end else begin
			g = euclid_gcd((n < 0) ? -n : n, d);
			n = n / longint'(g);
			d = d / longint'(g);
		end
		f.num = n[31:0];
		f.den = d[30:0];
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fraction_t exp_f;
		if (!arst_n) begin
			errors = 0;
			awaited_fractions.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (awaited_fractions.size() == 0) begin
					$error("result with no transaction outstanding");
					errors++;
				end else begin
					exp_f = awaited_fractions.pop_front();
					if (result_num !== exp_f.num) begin
						$error("result_num expected %0d got %0d", exp_f.num, result_num);
						errors++;
					end
					if (result_den !== exp_f.den) begin
						$error("result_den expected %0d got %0d", exp_f.den, result_den);
						errors++;
					end
					if (compare_true !== exp_f.cmp) begin
						$error("compare_true expected %0b got %0b", exp_f.cmp, compare_true);
						errors++;
					end
					if (divide_by_zero !== exp_f.dz) begin
						$error("divide_by_zero expected %0b got %0b", exp_f.dz,
							divide_by_zero);
						errors++;
					end
				end
			end
			if (start && !busy)
				awaited_fractions.push_back(reduce_fraction(command, operand_a_num,
					operand_a_den, operand_b_num, operand_b_den));
			pending = awaited_fractions.size();
		end
	end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// directed and random fraction transactions against the rational unit
// ----------------------------------------------------------------------------
module tb;
	import rau_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done;
	logic [3:0] command = CMD_ADD;
	logic signed [15:0] operand_a_num = 0;
	logic [14:0] operand_a_den = 1;
	logic signed [15:0] operand_b_num = 0;
	logic [14:0] operand_b_den = 1;
	logic signed [31:0] result_num;
	logic [30:0] result_den;
	logic compare_true, divide_by_zero;
	int errors, pending;
	int issued = 0;

	localparam int RANDOM_ITEMS = 550;

	always #4 clk = ~clk;

	rational_arithmetic_unit dut (.*);

	rau_checker checker_i (.*);

	// one transaction: hold start until the unit takes it
	task automatic send_fraction(logic [3:0] op, logic [15:0] an, logic [14:0] ad,
			logic [15:0] bn, logic [14:0] bd);
		bit taken;
		command = op;
		operand_a_num = an;
		operand_a_den = ad;
		operand_b_num = bn;
		operand_b_den = bd;
		start = 1;
		taken = 0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end
		start = 0;
		issued++;
	endtask

	// random idle burst from the sender, none near the end of the run
	task automatic maybe_idle();
		int gap;
		if (issued < RANDOM_ITEMS - 80 && $urandom_range(3) == 0) begin
			gap = $urandom_range(18, 1);
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic [14:0] pick_den();
		case ($urandom_range(19))
			0: return 0;              // zero denominator, operands used raw
			1: return 15'h7fff;
			2, 3, 4: return 15'($urandom_range(12, 1));
			default: return 15'($urandom_range(32767, 1));
		endcase
	endfunction

	function automatic logic [15:0] pick_num();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 0;
			3, 4: return 16'($urandom_range(24) - 12);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [3:0] op;
		logic [15:0] an;
		logic [14:0] ad;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, every command, special cases
		send_fraction(CMD_ADD, 16'h7fff, 1, 16'h7fff, 1);       // widest sum
		send_fraction(CMD_SUB, 16'h8000, 1, 16'h7fff, 1);
		send_fraction(CMD_MUL, 16'h8000, 15'h7fff, 16'h8000, 15'h7fff);
		send_fraction(CMD_DIV, 3, 4, -16'sd5, 6);               // sign moves to numerator
		send_fraction(CMD_DIV, 7, 9, 0, 2);                     // divide by zero
		send_fraction(CMD_SUB, 5, 6, 5, 6);                     // zero result
		send_fraction(CMD_ADD, 1, 2, 1, 2);                     // reduces to 1/1
		send_fraction(CMD_MUL, 0, 15'h7fff, 16'h8000, 1);
		send_fraction(CMD_ADD, 3, 0, 4, 5);                     // zero denominator operand
		send_fraction(CMD_DIV, 16'h8000, 1, 16'h8000, 15'h7fff);
		send_fraction(CMD_EQ, 1, 2, 2, 4);
		send_fraction(CMD_NE, 1, 2, 2, 4);
		send_fraction(CMD_GE, -16'sd1, 3, -16'sd1, 2);
		send_fraction(CMD_LE, -16'sd1, 3, -16'sd1, 2);
		send_fraction(CMD_GT, 16'h7fff, 1, 16'h8000, 1);
		send_fraction(CMD_LT, 16'h7fff, 1, 16'h8000, 1);
		send_fraction(CMD_EQ, 3, 0, 5, 0);                      // raw cross products
		send_fraction(4'd10, 1, 1, 1, 1);                       // unused codes
		send_fraction(4'd15, 16'h7fff, 15'h7fff, 16'h8000, 15'h7fff);

		// random part
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				while (pending != 0) @(negedge clk);    // let the pipe drain once
			op = ($urandom_range(15) == 0) ? 4'($urandom_range(15, 10))
				: 4'($urandom_range(9));
			an = pick_num();
			ad = pick_den();
			// some equal fractions so equality comparisons come out true
			if (op >= CMD_EQ && op <= CMD_LT && $urandom_range(3) == 0)
				send_fraction(op, an, ad, an, ad);
			else
				send_fraction(op, an, ad, pick_num(), pick_den());
			maybe_idle();
		end

		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/rau_pkg.sv
rtl/core/rau_datapath.sv
rtl/core/rau_ctrl.sv
rtl/core/rational_arithmetic_unit.sv
dv/rau_checker.sv
dv/tb.sv
